// ===== src/wraparound_aware_moving_average_defines.svh =====
// Assertion macros shared by the wrap-aware moving average RTL.
`ifndef WRAPAROUND_AWARE_MOVING_AVERAGE_DEFINES_SVH
`define WRAPAROUND_AWARE_MOVING_AVERAGE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WAMA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wama assertion failed");

// Next-cycle implication, disabled during reset.
`define WAMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wama assertion failed");

`endif

// ===== src/wama_pkg.sv =====
// Shared types and constants for the wrap-aware moving average.
package wama_pkg;

    localparam int SAMPLE_W      = 12;
    localparam int FOLD_W        = 13;
    localparam int QUOT_W        = 13;
    localparam int FILL_W        = 4;
    localparam int DEFAULT_DEPTH = 8;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;
    localparam logic [SAMPLE_W-1:0] HALF_SCALE = 12'd2048;
    localparam logic [FOLD_W-1:0]   RANGE_SPAN = 13'd4096;

    // Request modes; the unused code behaves as a query
    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]          mode;
        logic [SAMPLE_W-1:0] sample;
    } in_req_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic [FILL_W-1:0]   fill_count;
        logic                wrapped;
    } out_req_t;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

// ===== src/wama_cell.sv =====
// One window cell: holds a sample and its valid flag, passes both to its neighbor.
module wama_cell
    import wama_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cell_ctrl_t          ctrl,
    input  logic [SAMPLE_W-1:0] data_in,
    input  logic                valid_in,
    output logic [SAMPLE_W-1:0] data_out,
    output logic                valid_out
);

    logic [SAMPLE_W-1:0] data_reg;
    logic                valid_reg;

    // Valid flag: cleared by reset or clear, shifted otherwise
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_reg <= valid_in;
        end
    end

    // Sample data, meaningful only while valid
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            data_reg <= data_in;
        end
    end

    assign data_out  = data_reg;
    assign valid_out = valid_reg;

endmodule

// ===== src/wama_div.sv =====
// Shift-subtract divider, one quotient bit per cycle, quotient below 2**QUOT_W.
module wama_div
    import wama_pkg::*;
#(
    parameter int DIVIDEND_W = 17,
    parameter int DIVISOR_W  = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [QUOT_W-1:0]     quotient
);

    localparam int CMP_W  = (DIVIDEND_W > DIVISOR_W + QUOT_W) ? DIVIDEND_W
                                                               : DIVISOR_W + QUOT_W;
    localparam int STEP_W = $clog2(QUOT_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUOT_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CMP_W-1:0]  rem_reg;
    logic [CMP_W-1:0]  dsh_reg;
    logic [QUOT_W-1:0] q_reg;
    logic              fits;

    assign fits = (rem_reg >= dsh_reg);

    // Control: busy while stepping through the quotient bits, then a one-cycle done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: compare against the shifted divisor, subtract on fit
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= CMP_W'(dividend);
            dsh_reg <= CMP_W'(divisor) << (QUOT_W - 1);
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= {q_reg[QUOT_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== src/wraparound_aware_moving_average.sv =====
// Wrap-aware moving average of 12-bit position samples: a chain of sample cells,
// a scan that finds min, max and the folded sum, and a shift-subtract divider.
// Each request passes the scan, fold, divide and done states before its result is
// offered, and skips the divider when the window is empty. The rotation of the cell
// chain walks every held sample past the scan logic once, followed by the 13-step
// divider. A new request is taken only once the previous one has been handed to
// the result register; a finished result may wait there while the next request
// is accepted.
module wraparound_aware_moving_average
    import wama_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEFAULT_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  in_req_t  req_data,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output out_req_t rsp_data
);

`include "wraparound_aware_moving_average_defines.svh"

    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = $clog2(WINDOW_DEPTH * 8191 + 1);
    localparam int SCAN_W = $clog2(WINDOW_DEPTH);
    localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(WINDOW_DEPTH);
    localparam logic [SCAN_W-1:0] LAST_SCAN = SCAN_W'(WINDOW_DEPTH - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_FOLD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    held_count_reg;
    logic [SUM_W-1:0]    running_sum_reg;
    logic [SCAN_W-1:0]   scan_reg;
    logic [SAMPLE_W-1:0] lo_reg, hi_reg;
    logic [SUM_W-1:0]    acc_reg;
    logic                wrapped_reg;
    logic [SAMPLE_W-1:0] avg_reg;
    logic                rsp_valid_reg;
    out_req_t            rsp_data_reg;

    logic                accept;
    logic                is_push, is_clear, full;
    cell_ctrl_t          ctrl;
    logic [SAMPLE_W-1:0] head_data;
    logic                head_valid;
    logic [SAMPLE_W-1:0] cell_data  [WINDOW_DEPTH];
    logic                cell_valid [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] tail_data;
    logic                tail_valid;
    logic [FOLD_W-1:0]   tail_fold;
    logic [SAMPLE_W-1:0] spread;
    logic                span_wrap;
    logic                div_start;
    logic [SUM_W-1:0]    div_dividend;
    logic                div_done;
    logic [QUOT_W-1:0]   div_quot;
    logic                rsp_free;

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign is_push   = (req_data.mode == MODE_PUSH);
    assign is_clear  = (req_data.mode == MODE_CLEAR);
    assign full      = (held_count_reg == DEPTH_CNT);
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    assign tail_data  = cell_data[WINDOW_DEPTH-1];
    assign tail_valid = cell_valid[WINDOW_DEPTH-1];
    assign tail_fold  = (tail_data < HALF_SCALE) ? (FOLD_W'(tail_data) + RANGE_SPAN)
                                                 : FOLD_W'(tail_data);

    // Chain control: a push shifts a new sample in, the scan rotates the ring
    assign ctrl.shift = (accept && is_push) || (state_reg == ST_SCAN);
    assign ctrl.clear = accept && is_clear;
    assign head_data  = (state_reg == ST_SCAN) ? tail_data  : req_data.sample;
    assign head_valid = (state_reg == ST_SCAN) ? tail_valid : 1'b1;

    // Row of sample cells
    for (genvar i = 0; i < WINDOW_DEPTH; i++)
    begin : g_cell
        wama_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .data_in   ((i == 0) ? head_data  : cell_data[(i == 0) ? 0 : i - 1]),
            .valid_in  ((i == 0) ? head_valid : cell_valid[(i == 0) ? 0 : i - 1]),
            .data_out  (cell_data[i]),
            .valid_out (cell_valid[i])
        );
    end

    // Wrap decision from the scanned extremes
    assign spread       = hi_reg - lo_reg;
    assign span_wrap    = (hi_reg >= lo_reg) && (spread > HALF_SCALE);
    assign div_start    = (state_reg == ST_FOLD) && (held_count_reg != '0);
    assign div_dividend = span_wrap ? acc_reg : running_sum_reg;

    wama_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (held_count_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_SCAN;
            ST_SCAN: if (scan_reg == LAST_SCAN) state_next = ST_FOLD;
            ST_FOLD: state_next = (held_count_reg == '0) ? ST_DONE : ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_DONE;
            ST_DONE: if (rsp_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state: sequencer, fill count, running sum, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            held_count_reg  <= '0;
            running_sum_reg <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && is_clear)
            begin
                held_count_reg  <= '0;
                running_sum_reg <= '0;
            end
            else if (accept && is_push)
            begin
                if (full)
                begin
                    running_sum_reg <= running_sum_reg - SUM_W'(tail_data)
                                       + SUM_W'(req_data.sample);
                end
                else
                begin
                    held_count_reg  <= held_count_reg + 1'b1;
                    running_sum_reg <= running_sum_reg + SUM_W'(req_data.sample);
                end
            end
            if ((state_reg == ST_DONE) && rsp_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Scan accumulators and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            scan_reg <= '0;
            lo_reg   <= FULL_SCALE;
            hi_reg   <= '0;
            acc_reg  <= '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            scan_reg <= scan_reg + 1'b1;
            if (tail_valid)
            begin
                if (tail_data < lo_reg) lo_reg <= tail_data;
                if (tail_data > hi_reg) hi_reg <= tail_data;
                acc_reg <= acc_reg + SUM_W'(tail_fold);
            end
        end
        if (state_reg == ST_FOLD)
        begin
            wrapped_reg <= (held_count_reg != '0) && span_wrap;
            avg_reg     <= '0;
        end
        if ((state_reg == ST_DIV) && div_done)
        begin
            avg_reg <= div_quot[SAMPLE_W-1:0];
        end
        if ((state_reg == ST_DONE) && rsp_free)
        begin
            rsp_data_reg.average    <= avg_reg;
            rsp_data_reg.fill_count <= FILL_W'(held_count_reg);
            rsp_data_reg.wrapped    <= wrapped_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // Checks
    `WAMA_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, held_count_reg <= DEPTH_CNT)
    `WAMA_ASSERT_NOW(a_empty_sum, clk, rst_n, held_count_reg == '0, running_sum_reg == '0)
    `WAMA_ASSERT_NEXT(a_full_stays, clk, rst_n, accept && is_push && full, full)
    `WAMA_ASSERT_NOW(a_wrap_nonempty, clk, rst_n, (state_reg == ST_DONE) && wrapped_reg,
        held_count_reg != '0)

endmodule

// ===== tb/tb_wraparound_aware_moving_average.sv =====
// Testbench for the wrap-aware moving average: directed table, random requests, scoreboard.
module tb_wraparound_aware_moving_average;
    import wama_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         DEPTH          = DEFAULT_DEPTH;
    localparam logic [1:0] MODE_UNUSED    = 2'd3;
    localparam int         RANDOM_PER_PHASE = 213;
    localparam int         DRAIN_CYCLES   = 2 * (DEPTH + 17);
    localparam int         CYCLE_LIMIT    = 300000;
    localparam int         REPORT_LIMIT   = 10;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    in_req_t  req_data;
    logic     rsp_valid;
    logic     rsp_ready;
    out_req_t rsp_data;

    // One row of the directed table; a typed row carries its own expected result
    typedef struct {
        in_req_t  req;
        bit       typed;
        out_req_t want;
    } table_row_t;

    table_row_t directed_rows[$];
    out_req_t   pending_averages[$];

    // Predictor state
    logic [SAMPLE_W-1:0] win_samples [DEPTH];
    logic [14:0]         win_sum;
    int                  win_pos;
    int                  win_held;

    int send_idle_pct;
    int rsp_stall_pct;
    int mismatch_count;
    int cycle_count;

    wraparound_aware_moving_average u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Clear the predicted window back to its reset contents
    function automatic void clear_window();
        for (int i = 0; i < DEPTH; i++)
        begin
            win_samples[i] = '0;
        end
        win_sum  = '0;
        win_pos  = 0;
        win_held = 0;
    endfunction

    // Apply one request to the predicted window and return the average it reports
    function automatic out_req_t advance_window(in_req_t r);
        out_req_t            o;
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        int                  folded_sum;
        o = '0;
        case (r.mode)
            MODE_PUSH:
            begin
                if (win_held < DEPTH)
                    win_held++;
                else
                    win_sum = win_sum - 15'(win_samples[win_pos]);
                win_samples[win_pos] = r.sample;
                win_sum = win_sum + 15'(r.sample);
                win_pos = (win_pos + 1) % DEPTH;
            end
            MODE_CLEAR: clear_window();
            default: ;
        endcase
        o.fill_count = FILL_W'(win_held);
        if (win_held == 0)
            return o;
        lo = FULL_SCALE;
        hi = '0;
        for (int i = 0; i < win_held; i++)
        begin
            if (win_samples[i] < lo) lo = win_samples[i];
            if (win_samples[i] > hi) hi = win_samples[i];
        end
        // Spread over half scale: the samples straddle the roll-over, fold the low ones up
        if (int'(hi) - int'(lo) > int'(HALF_SCALE))
        begin
            folded_sum = 0;
            for (int i = 0; i < win_held; i++)
            begin
                folded_sum += (win_samples[i] < HALF_SCALE) ?
                              int'(win_samples[i]) + int'(RANGE_SPAN) : int'(win_samples[i]);
            end
            o.average = SAMPLE_W'(folded_sum / win_held);
            o.wrapped = 1'b1;
        end
        else
        begin
            o.average = SAMPLE_W'(int'(win_sum) / win_held);
        end
        return o;
    endfunction

    function automatic void add_row(logic [1:0] mode, logic [SAMPLE_W-1:0] sample, bit typed,
                                    logic [SAMPLE_W-1:0] avg, logic [FILL_W-1:0] fill,
                                    logic wrap);
        table_row_t row;
        row.req.mode        = mode;
        row.req.sample      = sample;
        row.typed           = typed;
        row.want.average    = avg;
        row.want.fill_count = fill;
        row.want.wrapped    = wrap;
        directed_rows.push_back(row);
    endfunction

    // Sample values clustered at both ends of the scale so the window often straddles the wrap
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int bucket;
        bucket = $urandom_range(99);
        if (bucket < 35)
            return SAMPLE_W'($urandom_range(300));
        else if (bucket < 70)
            return SAMPLE_W'($urandom_range(4095, 3795));
        else
            return SAMPLE_W'($urandom_range(4095));
    endfunction

    function automatic in_req_t pick_request();
        in_req_t r;
        int      roll;
        roll     = $urandom_range(99);
        r.sample = pick_sample();
        if (roll < 73)
            r.mode = MODE_PUSH;
        else if (roll < 85)
            r.mode = MODE_QUERY;
        else if (roll < 92)
            r.mode = MODE_UNUSED;
        else if (roll < 96)
            r.mode = MODE_CLEAR;
        else
            r.mode = MODE_PUSH;
        return r;
    endfunction

    // Offer one request, hold it until accepted, then record what it should return.
    // Called just after a rising edge; valid stays high when no gap is inserted.
    task automatic send_request(in_req_t r, bit typed, out_req_t want);
        out_req_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = advance_window(r);
        pending_averages.push_back(typed ? want : predicted);
    endtask

    // Hold off the sender until every outstanding result has been returned
    task automatic wait_for_drain();
        req_valid <= 1'b0;
        while (pending_averages.size() != 0)
            @(posedge clk);
    endtask

    // Receiver back-pressure
    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    // Result checker
    always @(posedge clk)
    begin : rsp_monitor
        out_req_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_averages.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result: average %0d fill %0d wrapped %0b",
                             rsp_data.average, rsp_data.fill_count, rsp_data.wrapped);
            end
            else
            begin
                want = pending_averages.pop_front();
                if (rsp_data.average !== want.average ||
                    rsp_data.fill_count !== want.fill_count ||
                    rsp_data.wrapped !== want.wrapped)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch: expected avg %0d fill %0d wrap %0b, got avg %0d fill %0d wrap %0b",
                                 want.average, want.fill_count, want.wrapped,
                                 rsp_data.average, rsp_data.fill_count, rsp_data.wrapped);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        out_req_t no_want;
        no_want        = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        rsp_stall_pct  = 0;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_data  <= '0;
        rsp_ready <= 1'b0;
        clear_window();

        // Directed table: empty window, unused mode, clear, extremes, full-window
        // overwrite, spread of exactly half scale versus just over it
        add_row(MODE_QUERY,  12'd0,    1, 12'd0,    4'd0, 1'b0);
        add_row(MODE_UNUSED, 12'hFFF,  1, 12'd0,    4'd0, 1'b0);
        add_row(MODE_CLEAR,  12'hABC,  1, 12'd0,    4'd0, 1'b0);
        add_row(MODE_PUSH,   12'd0,    1, 12'd0,    4'd1, 1'b0);
        add_row(MODE_PUSH,   12'd4095, 0, '0, '0, 1'b0);
        add_row(MODE_QUERY,  12'd0,    0, '0, '0, 1'b0);
        add_row(MODE_PUSH,   12'd2048, 0, '0, '0, 1'b0);
        add_row(MODE_CLEAR,  12'd0,    1, 12'd0,    4'd0, 1'b0);
        for (int k = 1; k <= DEPTH; k++)
            add_row(MODE_PUSH, 12'd4095, 1, 12'd4095, FILL_W'(k), 1'b0);
        add_row(MODE_PUSH,   12'h555,  0, '0, '0, 1'b0);
        add_row(MODE_PUSH,   12'd0,    0, '0, '0, 1'b0);
        add_row(MODE_UNUSED, 12'h555,  0, '0, '0, 1'b0);
        add_row(MODE_CLEAR,  12'hFFF,  1, 12'd0,    4'd0, 1'b0);
        add_row(MODE_PUSH,   12'd0,    1, 12'd0,    4'd1, 1'b0);
        add_row(MODE_PUSH,   12'd2048, 1, 12'd1024, 4'd2, 1'b0);
        add_row(MODE_PUSH,   12'd2049, 0, '0, '0, 1'b0);
        add_row(MODE_PUSH,   12'hAAA,  0, '0, '0, 1'b0);
        add_row(MODE_CLEAR,  12'd0,    1, 12'd0,    4'd0, 1'b0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        wait_for_drain();

        // Random phases: no idling, sender gaps, receiver stalls, both
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                1: begin send_idle_pct = 78; rsp_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rsp_stall_pct = 78; end
                default: begin send_idle_pct = 22; rsp_stall_pct = 22; end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_request(pick_request(), 0, no_want);
            wait_for_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/wama_pkg.sv
src/wama_cell.sv
src/wama_div.sv
src/wraparound_aware_moving_average.sv
tb/tb_wraparound_aware_moving_average.sv
